>>> rtl/pidd_pkg.sv
// ----------------------------------------------------------------------------
// pidd_pkg
// Shared widths, constants, microcode encoding and control store of the
// deadband PID controller.
// ----------------------------------------------------------------------------
package pidd_pkg;

  // Field and register widths
  localparam int MEAS_W   = 13;
  localparam int GAIN_W   = 32;
  localparam int BAND_W   = 13;
  localparam int TSTEP_W  = 16;
  localparam int DRIVE_W  = 48;
  localparam int CFG_IX_W = 3;
  localparam int CFG_D_W  = 32;
  localparam int ERR_W    = 11;
  localparam int DIFF_W   = 12;
  localparam int INTEG_W  = 31;
  localparam int ACC_W    = 64;
  localparam int PC_W     = 5;
  localparam int CNT_W    = 5;

  // Register indexes
  localparam logic [CFG_IX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [CFG_IX_W-1:0] REG_GAIN_P = 3'd1;
  localparam logic [CFG_IX_W-1:0] REG_GAIN_I = 3'd2;
  localparam logic [CFG_IX_W-1:0] REG_GAIN_D = 3'd3;
  localparam logic [CFG_IX_W-1:0] REG_BAND   = 3'd4;
  localparam logic [CFG_IX_W-1:0] REG_TSTEP  = 3'd5;

  // Arithmetic constants
  localparam logic [12:0] ERR_RECIP   = 13'd6554;   // ceil(2^16 / 10)
  localparam logic signed [31:0] INTEG_LIMIT = 32'sd666666666;
  localparam logic [TSTEP_W-1:0] DRIVE_SCALE = 16'd1000;
  localparam int SCALE_SHIFT = 10;                   // 2^10 = DRIVE_SCALE + 24
  localparam logic [CNT_W-1:0] DERIV_ITERS = 5'd5;  // 6 radix-4 steps
  localparam logic [CNT_W-1:0] DRIVE_ITERS = 5'd12; // 13 reduction steps

  // Datapath operations
  localparam logic [3:0] OP_NOP     = 4'd0;
  localparam logic [3:0] OP_ERR     = 4'd1;
  localparam logic [3:0] OP_INTEG   = 4'd2;
  localparam logic [3:0] OP_DLOAD_D = 4'd3;
  localparam logic [3:0] OP_DSTEP   = 4'd4;
  localparam logic [3:0] OP_DERIV   = 4'd5;
  localparam logic [3:0] OP_MUL_P   = 4'd6;
  localparam logic [3:0] OP_MUL_I   = 4'd7;
  localparam logic [3:0] OP_MUL_D   = 4'd8;
  localparam logic [3:0] OP_ACC     = 4'd9;
  localparam logic [3:0] OP_DLOAD_A = 4'd10;
  localparam logic [3:0] OP_SAT     = 4'd11;
  localparam logic [3:0] OP_OUT     = 4'd12;
  localparam logic [3:0] OP_CLEAR   = 4'd13;
  localparam logic [3:0] OP_QSTEP   = 4'd14;
  localparam logic [3:0] OP_QFIX    = 4'd15;

  // Jump conditions
  localparam logic [2:0] COND_NONE     = 3'd0;
  localparam logic [2:0] COND_ALWAYS   = 3'd1;
  localparam logic [2:0] COND_NO_INPUT = 3'd2;
  localparam logic [2:0] COND_CLEAR    = 3'd3;
  localparam logic [2:0] COND_DIV_MORE = 3'd4;
  localparam logic [2:0] COND_OUT_BUSY = 3'd5;

  // Program addresses used as jump targets
  localparam logic [PC_W-1:0] STEP_IDLE    = 5'd0;
  localparam logic [PC_W-1:0] STEP_DLOOP_D = 5'd5;
  localparam logic [PC_W-1:0] STEP_DLOOP_A = 5'd12;
  localparam logic [PC_W-1:0] STEP_OUT     = 5'd15;
  localparam logic [PC_W-1:0] STEP_CLEAR   = 5'd17;

  typedef struct packed {
    logic [3:0]      op;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // Control store: one word per step
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      5'd0:    w = '{OP_NOP,     COND_NO_INPUT, STEP_IDLE};
      5'd1:    w = '{OP_NOP,     COND_CLEAR,    STEP_CLEAR};
      5'd2:    w = '{OP_ERR,     COND_NONE,     STEP_IDLE};
      5'd3:    w = '{OP_INTEG,   COND_NONE,     STEP_IDLE};
      5'd4:    w = '{OP_DLOAD_D, COND_NONE,     STEP_IDLE};
      5'd5:    w = '{OP_DSTEP,   COND_DIV_MORE, STEP_DLOOP_D};
      5'd6:    w = '{OP_DERIV,   COND_NONE,     STEP_IDLE};
      5'd7:    w = '{OP_MUL_P,   COND_NONE,     STEP_IDLE};
      5'd8:    w = '{OP_MUL_I,   COND_NONE,     STEP_IDLE};
      5'd9:    w = '{OP_MUL_D,   COND_NONE,     STEP_IDLE};
      5'd10:   w = '{OP_ACC,     COND_NONE,     STEP_IDLE};
      5'd11:   w = '{OP_DLOAD_A, COND_NONE,     STEP_IDLE};
      5'd12:   w = '{OP_QSTEP,   COND_DIV_MORE, STEP_DLOOP_A};
      5'd13:   w = '{OP_QFIX,    COND_NONE,     STEP_IDLE};
      5'd14:   w = '{OP_SAT,     COND_NONE,     STEP_IDLE};
      5'd15:   w = '{OP_OUT,     COND_OUT_BUSY, STEP_OUT};
      5'd16:   w = '{OP_NOP,     COND_ALWAYS,   STEP_IDLE};
      5'd17:   w = '{OP_CLEAR,   COND_ALWAYS,   STEP_OUT};
      default: w = '{OP_NOP,     COND_ALWAYS,   STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/pid_controller_deadband.sv
// ----------------------------------------------------------------------------
// pid_controller_deadband
// PID loop with error deadband, clamped integral and saturated Q32.16 drive,
// run by a microcoded sequencer over one shared multiplier and divider.
// ----------------------------------------------------------------------------
// A control transaction runs the error, integral, derivative division,
// product, gain sum, reduction, saturation and output steps; a clear one
// clears the loop memory and goes to the output step. The derivative over
// the time step takes 6 iterations of the shared radix-4 restoring
// divider, and 13 reduction steps divide the 64-bit gain sum by 1000. A
// result that waits in a stalled output register holds the program at its
// output step. One transaction is worked on at a time; the next is accepted
// once the program returns to its idle step, even while a result still
// waits in the output register. Configuration registers must be written by
// the user only while idle; the block itself does not enforce this.
module pid_controller_deadband (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [pidd_pkg::CFG_IX_W-1:0]          cfg_index,
  input  logic [pidd_pkg::CFG_D_W-1:0]           cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_action,
  input  logic signed [pidd_pkg::MEAS_W-1:0]     in_measured,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [pidd_pkg::DRIVE_W-1:0]    out_drive
);
  import pidd_pkg::*;

  // Configuration registers
  logic signed [MEAS_W-1:0]  target_r;
  logic signed [GAIN_W-1:0]  gain_p_r, gain_i_r, gain_d_r;
  logic [BAND_W-1:0]         band_r;
  logic [TSTEP_W-1:0]        tstep_r;

  // Sequencer
  logic [PC_W-1:0]  pc_r, pc_nxt;
  uword_t           uw;
  logic             take_jump;

  // Loop state and datapath registers
  logic                        act_r;
  logic signed [MEAS_W-1:0]    meas_r;
  logic signed [ERR_W-1:0]     err_r, prev_r;
  logic signed [INTEG_W-1:0]   integ_r;
  logic signed [DIFF_W-1:0]    deriv_r;
  logic signed [ACC_W-1:0]     prod_r, acc_r;
  logic [ACC_W-1:0]            dvd_r;
  logic [ACC_W-1:0]            qrem_r;
  logic [TSTEP_W-1:0]          rem_r, dsr_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        qneg_r;
  logic signed [DRIVE_W-1:0]   res_r;
  logic                        out_valid_r;
  logic signed [DRIVE_W-1:0]   out_drive_r;

  // Combinational datapath signals
  logic signed [MEAS_W:0]      raw_w;
  logic [MEAS_W:0]             mag_w;
  logic [26:0]                 recip_w;
  logic [ERR_W-1:0]            quo_w;
  logic signed [ERR_W-1:0]     err_w;
  logic signed [31:0]          isum_w;
  logic signed [INTEG_W-1:0]   isat_w;
  logic signed [DIFF_W-1:0]    diff_w;
  logic [DIFF_W-1:0]           dmag_w;
  logic signed [GAIN_W-1:0]    mul_a;
  logic signed [31:0]          mul_b;
  logic signed [ACC_W-1:0]     prod_w;
  logic [ACC_W-1:0]            amag_w;
  logic [TSTEP_W:0]            t1_w, t2_w;
  logic                        ge1_w, ge2_w;
  logic [TSTEP_W-1:0]          r1_w, r2_w;
  logic [ACC_W-1:0]            d1_w, d2_w;
  logic [ACC_W-1:0]            fold_w, qred_w;
  logic signed [DRIVE_W-1:0]   sat_w;
  logic                        out_free;

  // Handshake
  assign in_stall  = (pc_r != STEP_IDLE);
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;
  assign out_free  = !(out_valid_r && out_stall);

  // Fetch control word and pick the next step
  assign uw = ucode_rom(pc_r);

  always_comb begin
    case (uw.cond)
      COND_NONE:     take_jump = 1'b0;
      COND_ALWAYS:   take_jump = 1'b1;
      COND_NO_INPUT: take_jump = !in_valid;
      COND_CLEAR:    take_jump = act_r;
      COND_DIV_MORE: take_jump = (cnt_r != '0);
      COND_OUT_BUSY: take_jump = !out_free;
      default:       take_jump = 1'b0;
    endcase
    pc_nxt = take_jump ? uw.target : pc_r + 1'b1;
  end

  // Scaled error: deadband, then divide by ten through a reciprocal
  always_comb begin
    raw_w   = (MEAS_W+1)'(target_r) - (MEAS_W+1)'(meas_r);
    mag_w   = raw_w[MEAS_W] ? (MEAS_W+1)'(-raw_w) : raw_w;
    if (mag_w < {1'b0, band_r}) begin
      mag_w = '0;
    end
    recip_w = {13'b0, mag_w} * {14'b0, ERR_RECIP};
    quo_w   = recip_w[26:16];
    err_w   = raw_w[MEAS_W] ? -$signed(quo_w) : $signed(quo_w);
  end

  // Clamped integral
  always_comb begin
    isum_w = 32'(integ_r) + 32'(err_r);
    if (isum_w > INTEG_LIMIT) begin
      isat_w = INTEG_W'(INTEG_LIMIT);
    end else if (isum_w < -INTEG_LIMIT) begin
      isat_w = INTEG_W'(-INTEG_LIMIT);
    end else begin
      isat_w = isum_w[INTEG_W-1:0];
    end
  end

  // Error difference for the derivative
  assign diff_w = DIFF_W'(err_r) - DIFF_W'(prev_r);
  assign dmag_w = diff_w[DIFF_W-1] ? DIFF_W'(-diff_w) : diff_w;

  // Shared multiplier, operands chosen by the current operation
  always_comb begin
    case (uw.op)
      OP_MUL_P: begin
        mul_a = gain_p_r;
        mul_b = 32'(err_r);
      end
      OP_MUL_I: begin
        mul_a = gain_i_r;
        mul_b = 32'(integ_r);
      end
      OP_MUL_D: begin
        mul_a = gain_d_r;
        mul_b = 32'(deriv_r);
      end
      default: begin
        mul_a = gain_p_r;
        mul_b = 32'(err_r);
      end
    endcase
    prod_w = mul_a * mul_b;
  end

  assign amag_w = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : acc_r;

  // Divider: two restoring steps per cycle
  always_comb begin
    t1_w  = {rem_r, dvd_r[ACC_W-1]};
    ge1_w = (t1_w >= {1'b0, dsr_r});
    r1_w  = ge1_w ? TSTEP_W'(t1_w - {1'b0, dsr_r}) : t1_w[TSTEP_W-1:0];
    d1_w  = {dvd_r[ACC_W-2:0], ge1_w};
    t2_w  = {r1_w, d1_w[ACC_W-1]};
    ge2_w = (t2_w >= {1'b0, dsr_r});
    r2_w  = ge2_w ? TSTEP_W'(t2_w - {1'b0, dsr_r}) : t2_w[TSTEP_W-1:0];
    d2_w  = {d1_w[ACC_W-2:0], ge2_w};
  end

  // Divide by 1000 = 2^10 - 24: count the part above bit 10 into the
  // quotient and fold it back into the remainder times 24
  assign fold_w = qrem_r >> SCALE_SHIFT;
  assign qred_w = ACC_W'(qrem_r[SCALE_SHIFT-1:0]) + (fold_w << 4) + (fold_w << 3);

  // Apply sign to the quotient and saturate to the drive width
  always_comb begin
    if (qneg_r) begin
      if (dvd_r > (ACC_W'(1) << (DRIVE_W-1))) begin
        sat_w = {1'b1, {(DRIVE_W-1){1'b0}}};
      end else begin
        sat_w = DRIVE_W'(-dvd_r);
      end
    end else begin
      if (dvd_r > ((ACC_W'(1) << (DRIVE_W-1)) - 1'b1)) begin
        sat_w = {1'b0, {(DRIVE_W-1){1'b1}}};
      end else begin
        sat_w = dvd_r[DRIVE_W-1:0];
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      band_r   <= '0;
      tstep_r  <= TSTEP_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET: target_r <= cfg_wdata[MEAS_W-1:0];
        REG_GAIN_P: gain_p_r <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I: gain_i_r <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D: gain_d_r <= cfg_wdata[GAIN_W-1:0];
        REG_BAND:   band_r   <= cfg_wdata[BAND_W-1:0];
        REG_TSTEP:  tstep_r  <= cfg_wdata[TSTEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, loop memory and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_IDLE;
      integ_r     <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      // load a finished result, drop it once taken
      if (uw.op == OP_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (uw.op)
        OP_INTEG: integ_r <= isat_w;
        OP_DLOAD_D: prev_r <= err_r;
        OP_CLEAR: begin
          integ_r <= '0;
          prev_r  <= '0;
        end
        default: ;
      endcase
    end
  end

  // Datapath payload registers
  always_ff @(posedge clk) begin
    // capture the transaction
    if (in_valid && !in_stall) begin
      act_r  <= in_action;
      meas_r <= in_measured;
    end
    case (uw.op)
      OP_ERR: err_r <= err_w;
      OP_DLOAD_D: begin
        dvd_r  <= {dmag_w, {(ACC_W-DIFF_W){1'b0}}};
        rem_r  <= '0;
        dsr_r  <= (tstep_r == '0) ? TSTEP_W'(1) : tstep_r;
        cnt_r  <= DERIV_ITERS;
        qneg_r <= diff_w[DIFF_W-1];
      end
      OP_DSTEP: begin
        dvd_r <= d2_w;
        rem_r <= r2_w;
        cnt_r <= cnt_r - 1'b1;
      end
      OP_DERIV: begin
        deriv_r <= qneg_r ? -$signed(dvd_r[DIFF_W-1:0]) : $signed(dvd_r[DIFF_W-1:0]);
      end
      OP_MUL_P: begin
        prod_r <= prod_w;
        acc_r  <= '0;
      end
      OP_MUL_I, OP_MUL_D: begin
        prod_r <= prod_w;
        acc_r  <= acc_r + prod_r;
      end
      OP_ACC: acc_r <= acc_r + prod_r;
      OP_DLOAD_A: begin
        dvd_r  <= '0;
        qrem_r <= amag_w;
        cnt_r  <= DRIVE_ITERS;
        qneg_r <= acc_r[ACC_W-1];
      end
      OP_QSTEP: begin
        dvd_r  <= dvd_r + fold_w;
        qrem_r <= qred_w;
        cnt_r  <= cnt_r - 1'b1;
      end
      // remainder is below 1024 here, so one subtract step finishes it
      OP_QFIX: begin
        if (qrem_r >= ACC_W'(DRIVE_SCALE)) begin
          dvd_r <= dvd_r + 1'b1;
        end
      end
      OP_SAT: res_r <= sat_w;
      OP_CLEAR: res_r <= '0;
      OP_OUT: begin
        if (out_free) begin
          out_drive_r <= res_r;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> test/pid_controller_deadband_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_deadband_tb
// Self-checking bench for the deadband PID controller. A queue-fed driver
// sends control and clear transactions with random gaps. A monitor checks
// every drive result against a cycle-free model of the loop (deadband,
// scaled error, clamped integral, derivative over the time step, gain sum
// divided down and saturated). The configuration changes only while idle.
// ----------------------------------------------------------------------------
module pid_controller_deadband_tb;
  import pidd_pkg::*;

  localparam logic ACT_STEP  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Indexes past the register map; writes there must be dropped
  localparam logic [CFG_IX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int     ERR_SCALE = 10;
  localparam longint OUT_SCALE = 1000;
  localparam longint DRIVE_HI  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint DRIVE_LO  = -64'sh0000_8000_0000_0000;

  localparam logic signed [MEAS_W-1:0] MEAS_MAX = 13'h0FFF;
  localparam logic signed [MEAS_W-1:0] MEAS_MIN = 13'h1000;

  localparam int IDLE_PCT      = 17;
  localparam int CALM_START    = 40000;
  localparam int CALM_END      = 55000;
  localparam int HOLD_AFTER    = 300;
  localparam int HOLD_LEN      = 400;
  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 60;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 204;

  typedef struct {
    logic                     action;
    logic signed [MEAS_W-1:0] measured;
  } ctrl_item_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [CFG_IX_W-1:0]             cfg_index = '0;
  logic [CFG_D_W-1:0]              cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_action = 1'b0;
  logic signed [MEAS_W-1:0]        in_measured = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic signed [DRIVE_W-1:0]       out_drive;

  // Controller model: configuration and loop memory
  int     setpoint = 0;
  longint kp = 0;
  longint ki = 0;
  longint kd = 0;
  int     band = 0;
  int     tstep_cfg = 1;
  longint integ_acc = 0;
  int     last_err = 0;

  ctrl_item_t                pending_items[$];
  logic signed [DRIVE_W-1:0] drive_expect[$];
  ctrl_item_t                send_item;
  logic signed [DRIVE_W-1:0] want_drive;
  bit                        in_taken = 1'b0;
  int                        cycle_cnt = 0;
  int                        quiet_cycles = 0;
  int                        results_seen = 0;
  int                        fail_count = 0;
  int                        hold_left = 0;
  bit                        hold_done = 1'b0;
  logic                      calm;

  assign calm = (cycle_cnt >= CALM_START) && (cycle_cnt < CALM_END);

  pid_controller_deadband i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_measured (in_measured),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_drive   (out_drive)
  );

  always #4 clk = ~clk;

  // Advance the loop by one transaction and return the drive it yields
  function automatic logic signed [DRIVE_W-1:0] next_drive(
    input logic act, input logic signed [MEAS_W-1:0] meas);
    int     raw_err;
    int     err;
    int     divisor;
    int     slope;
    longint sum;
    longint acc;
    if (act == ACT_CLEAR) begin
      integ_acc = 0;
      last_err = 0;
      return '0;
    end
    raw_err = setpoint - meas;
    if ((raw_err < 0 ? -raw_err : raw_err) < band) raw_err = 0;
    err = raw_err / ERR_SCALE;
    sum = integ_acc + err;
    if (sum > INTEG_LIMIT) sum = INTEG_LIMIT;
    else if (sum < -INTEG_LIMIT) sum = -INTEG_LIMIT;
    integ_acc = sum;
    divisor = (tstep_cfg == 0) ? 1 : tstep_cfg;
    slope = (err - last_err) / divisor;
    last_err = err;
    acc = kp * err + ki * integ_acc + kd * slope;
    acc = acc / OUT_SCALE;
    if (acc > DRIVE_HI) acc = DRIVE_HI;
    else if (acc < DRIVE_LO) acc = DRIVE_LO;
    return acc[DRIVE_W-1:0];
  endfunction

  // Write one register and mirror it into the model
  task automatic cfg_write(input logic [CFG_IX_W-1:0] idx, input logic [CFG_D_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_TARGET: setpoint = $signed(data[MEAS_W-1:0]);
      REG_GAIN_P: kp = $signed(data);
      REG_GAIN_I: ki = $signed(data);
      REG_GAIN_D: kd = $signed(data);
      REG_BAND:   band = data[BAND_W-1:0];
      REG_TSTEP:  tstep_cfg = data[TSTEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_item(input logic act, input int meas);
    ctrl_item_t it;
    it.action = act;
    it.measured = meas[MEAS_W-1:0];
    pending_items.push_back(it);
  endtask

  // Mix of clears and full-range, near-setpoint and deadband-edge measurements
  task automatic add_random_item();
    int m;
    if ($urandom_range(0, 99) < 6) begin
      add_item(ACT_CLEAR, $urandom);
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: m = $urandom;
        4, 5, 6, 7: m = setpoint + int'($urandom_range(0, 60)) - 30;
        default:    m = setpoint + ($urandom_range(0, 1) ? band : -band)
                        + int'($urandom_range(0, 2)) - 1;
      endcase
      add_item(ACT_STEP, m);
    end
  endtask

  function automatic logic [CFG_D_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1, 2:    return CFG_D_W'(int'($urandom_range(0, 262144)) - 131072);
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  // Hold until every transaction has been sent and answered, then settle
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || drive_expect.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_config();
    logic [CFG_D_W-1:0] wd;
    cfg_write(REG_TARGET, $urandom);
    cfg_write(REG_GAIN_P, pick_gain());
    cfg_write(REG_GAIN_I, pick_gain());
    cfg_write(REG_GAIN_D, pick_gain());
    wd = $urandom;
    if ($urandom_range(0, 3) != 0) wd[BAND_W-1:0] = BAND_W'($urandom_range(0, 200));
    cfg_write(REG_BAND, wd);
    wd = $urandom;
    case ($urandom_range(0, 3))
      0:       wd[TSTEP_W-1:0] = '0;
      1:       wd[TSTEP_W-1:0] = 16'd1;
      2:       wd[TSTEP_W-1:0] = TSTEP_W'($urandom_range(2, 8));
      default: ;
    endcase
    cfg_write(REG_TSTEP, wd);
  endtask

  // Sender: offer the next queued transaction, hold it while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        send_item = pending_items.pop_front();
        in_valid <= 1'b1;
        in_action <= send_item.action;
        in_measured <= send_item.measured;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict the drive of each accepted transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      drive_expect.push_back(next_drive(in_action, in_measured));
      in_taken = 1'b1;
    end
  end

  // Receiver: random stalls, one long hold-off to back up the block
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Compare each drive result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (drive_expect.size() == 0) begin
        $error("drive: unexpected transaction, actual %0d", out_drive);
        fail_count++;
      end else begin
        want_drive = drive_expect.pop_front();
        if (out_drive !== want_drive) begin
          $error("drive: expected %0d, actual %0d", want_drive, out_drive);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    cycle_cnt++;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration: zero gains give zero drive
    add_item(ACT_STEP, 100);
    add_item(ACT_STEP, MEAS_MIN);
    wait_idle();

    // Unit-ish gains, field extremes, truncation of the scaled error, clear
    cfg_write(REG_TARGET, 32'd0);
    cfg_write(REG_GAIN_P, 32'h0001_0000);
    cfg_write(REG_GAIN_I, 32'h0000_8000);
    cfg_write(REG_GAIN_D, 32'hFFFF_0000);
    cfg_write(REG_BAND, 32'd0);
    cfg_write(REG_TSTEP, 32'd1);
    add_item(ACT_STEP, MEAS_MAX);
    add_item(ACT_STEP, MEAS_MIN);
    add_item(ACT_STEP, -1);
    add_item(ACT_STEP, 9);
    add_item(ACT_STEP, -10);
    add_item(ACT_CLEAR, MEAS_MAX);
    add_item(ACT_STEP, MEAS_MAX);
    add_item(ACT_STEP, MEAS_MAX);
    wait_idle();

    // Deadband edges: magnitude just below, at and just above the band
    cfg_write(REG_TARGET, 32'd50);
    cfg_write(REG_BAND, 32'd100);
    add_item(ACT_STEP, 99);
    add_item(ACT_STEP, -50);
    add_item(ACT_STEP, -49);
    add_item(ACT_STEP, 150);
    add_item(ACT_STEP, 151);
    wait_idle();

    // Zero time step acts as one; then the largest time step
    cfg_write(REG_TSTEP, 32'hABCD_0000);
    add_item(ACT_STEP, 2000);
    add_item(ACT_STEP, -2000);
    wait_idle();
    cfg_write(REG_TSTEP, 32'h0000_FFFF);
    add_item(ACT_STEP, MEAS_MIN);
    add_item(ACT_STEP, MEAS_MAX);
    wait_idle();

    // Extreme gains and setpoints, widest deadband
    cfg_write(REG_TARGET, 32'hFFFF_EFFF);
    cfg_write(REG_GAIN_P, 32'h7FFF_FFFF);
    cfg_write(REG_GAIN_I, 32'h8000_0000);
    cfg_write(REG_GAIN_D, 32'h8000_0000);
    cfg_write(REG_BAND, 32'hFFFF_FFFF);
    add_item(ACT_STEP, MEAS_MIN);
    add_item(ACT_STEP, 0);
    wait_idle();
    cfg_write(REG_TARGET, 32'h0000_1000);
    cfg_write(REG_BAND, 32'd0);
    add_item(ACT_STEP, MEAS_MAX);
    add_item(ACT_STEP, MEAS_MAX);
    wait_idle();

    // Writes past the register map must leave the configuration alone
    cfg_write(REG_SPARE_LO, $urandom);
    cfg_write(REG_SPARE_HI, $urandom);
    add_item(ACT_STEP, 0);
    wait_idle();

    // Random phases, each with its own configuration
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_config();
      for (int n = 0; n < PHASE_ITEMS; n++) add_random_item();
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && drive_expect.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
